>>> rtl/core/rclfp_pkg.sv
// Shared types and constants of the rc link frame parser.
`default_nettype none
package rclfp_pkg;

  localparam int unsigned PAYLOAD_BYTES = 22;
  localparam int unsigned PAYLOAD_BITS  = PAYLOAD_BYTES * 8;
  localparam int unsigned CH_BITS       = 11;
  localparam int unsigned OUT_CNT_BITS  = 32;

  localparam logic [7:0] RC_TYPE  = 8'h16;
  localparam logic [7:0] RC_LEN   = 8'd24;
  localparam logic [7:0] LEN_MIN  = 8'd2;
  localparam logic [7:0] LEN_MAX  = 8'd62;
  localparam logic [7:0] CRC_POLY = 8'hD5;

  typedef enum logic [1:0] {
    EV_LEN_ERR = 2'd0,
    EV_CRC_ERR = 2'd1,
    EV_GOOD    = 2'd2,
    EV_CHANNEL = 2'd3
  } event_t;

  typedef struct packed {
    event_t                    kind;
    logic [7:0]                frame_type;
    logic [PAYLOAD_BITS-1:0]   payload;
  } job_t;

endpackage
`default_nettype wire

>>> rtl/core/rclfp_if.sv
// Handshake interfaces for the byte input and the result output.
`default_nettype none
interface rclfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rclfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [7:0]  frame_type;
  logic [3:0]  chan_num;
  logic [10:0] channel_value;
  logic        last;
  logic [31:0] good_frames;
  logic [31:0] crc_errors;
  logic [31:0] length_errors;
  logic [31:0] channel_frames;
  modport source (output valid, output event_res, output frame_type, output chan_num,
                  output channel_value, output last, output good_frames, output crc_errors,
                  output length_errors, output channel_frames, input ready);
  modport sink (input valid, input event_res, input frame_type, input chan_num,
                input channel_value, input last, input good_frames, input crc_errors,
                input length_errors, input channel_frames, output ready);
endinterface
`default_nettype wire

>>> rtl/core/rclfp_front.sv
// Front end: frame sync, length check, CRC and payload capture.
`default_nettype none
module rclfp_front
  import rclfp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_valid,
  input  wire logic [7:0] byte_data,
  output logic            byte_ready,
  output logic            push_valid,
  input  wire logic       push_ready,
  output job_t            push_job
);

  logic [6:0]              pos_r, pos_nxt;
  logic [6:0]              end_r, end_nxt;
  logic [7:0]              crc_r, crc_nxt;
  logic [7:0]              len_r, len_nxt;
  logic [7:0]              type_r, type_nxt;
  logic [PAYLOAD_BITS-1:0] payload_r, payload_nxt;
  logic                    fire;
  logic                    bad_len;

  function automatic logic is_addr(input logic [7:0] b);
    case (b)
      8'h00, 8'h10, 8'h12, 8'h80, 8'hC0, 8'hC2, 8'hC4,
      8'hC8, 8'hCA, 8'hCC, 8'hCE, 8'hEA, 8'hEC, 8'hEE: is_addr = 1'b1;
      default: is_addr = 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] x;
    x = c ^ b;
    for (int i = 0; i < 8; i++) begin
      if (x[7]) begin
        x = {x[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        x = {x[6:0], 1'b0};
      end
    end
    return x;
  endfunction

  assign byte_ready = push_ready;
  assign fire       = byte_valid && byte_ready;
  assign bad_len    = (byte_data < LEN_MIN) || (byte_data > LEN_MAX);

  always_comb begin
    pos_nxt     = pos_r;
    end_nxt     = end_r;
    crc_nxt     = crc_r;
    len_nxt     = len_r;
    type_nxt    = type_r;
    payload_nxt = payload_r;
    push_valid  = 1'b0;
    push_job    = '{kind: EV_LEN_ERR, frame_type: 8'd0, payload: payload_r};
    if (fire) begin
      if (pos_r == 7'd0) begin
        if (is_addr(byte_data)) begin
          pos_nxt = 7'd1;
        end
      end else if (pos_r == 7'd1) begin
        if (bad_len) begin
          push_valid = 1'b1;
          end_nxt    = 7'd0;
          pos_nxt    = is_addr(byte_data) ? 7'd1 : 7'd0;
        end else begin
          len_nxt = byte_data;
          end_nxt = byte_data[6:0] + 7'd2;
          crc_nxt = 8'd0;
          pos_nxt = 7'd2;
        end
      end else if (pos_r + 7'd1 < end_r) begin
        if (pos_r == 7'd2) begin
          type_nxt = byte_data;
        end else begin
          payload_nxt = {byte_data, payload_r[PAYLOAD_BITS-1:8]};
        end
        crc_nxt = crc_step(crc_r, byte_data);
        pos_nxt = pos_r + 7'd1;
      end else begin
        push_valid          = 1'b1;
        push_job.frame_type = type_r;
        if (byte_data != crc_r) begin
          push_job.kind = EV_CRC_ERR;
        end else if (type_r == RC_TYPE && len_r == RC_LEN) begin
          push_job.kind = EV_CHANNEL;
        end else begin
          push_job.kind = EV_GOOD;
        end
        pos_nxt = 7'd0;
        end_nxt = 7'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 7'd0;
      end_r <= 7'd0;
      crc_r <= 8'd0;
    end else begin
      pos_r <= pos_nxt;
      end_r <= end_nxt;
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r     <= len_nxt;
    type_r    <= type_nxt;
    payload_r <= payload_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/core/rclfp_queue.sv
// Two-entry queue of finished frames between front and back end.
`default_nettype none
module rclfp_queue
  import rclfp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire job_t push_job,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output job_t      pop_job
);

  job_t       mem_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_job    = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (do_push) begin
        wr_r <= ~wr_r;
      end
      if (do_pop) begin
        rd_r <= ~rd_r;
      end
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/rclfp_back.sv
// Back end: counters, channel unpacking and the result register.
`default_nettype none
module rclfp_back
  import rclfp_pkg::*;
#(
  parameter int unsigned CHANNEL_COUNT = 16,
  parameter int unsigned COUNTER_BITS  = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         job_valid,
  output logic              job_ready,
  input  wire job_t         job,
  output logic              res_valid,
  input  wire logic         res_ready,
  output logic [1:0]        res_event,
  output logic [7:0]        res_type,
  output logic [3:0]        res_index,
  output logic [10:0]       res_value,
  output logic              res_last,
  output logic [31:0]       res_good,
  output logic [31:0]       res_crc_err,
  output logic [31:0]       res_len_err,
  output logic [31:0]       res_ch_frames
);

  localparam logic [3:0] LAST_IDX = 4'(CHANNEL_COUNT - 1);

  logic [COUNTER_BITS-1:0] good_r, good_nxt;
  logic [COUNTER_BITS-1:0] crce_r, crce_nxt;
  logic [COUNTER_BITS-1:0] lene_r, lene_nxt;
  logic [COUNTER_BITS-1:0] chf_r, chf_nxt;
  logic                    active_r;
  logic [3:0]              idx_r;
  logic [PAYLOAD_BITS-1:0] sh_r;
  logic [7:0]              type_r;
  logic                    take;
  logic                    pop;

  assign take      = !res_valid || res_ready;
  assign pop       = take && !active_r && job_valid;
  assign job_ready = take && !active_r;

  always_comb begin
    good_nxt = good_r;
    crce_nxt = crce_r;
    lene_nxt = lene_r;
    chf_nxt  = chf_r;
    case (job.kind)
      EV_LEN_ERR: lene_nxt = lene_r + 1'b1;
      EV_CRC_ERR: crce_nxt = crce_r + 1'b1;
      EV_GOOD:    good_nxt = good_r + 1'b1;
      EV_CHANNEL: begin
        good_nxt = good_r + 1'b1;
        chf_nxt  = chf_r + 1'b1;
      end
      default: lene_nxt = lene_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_r    <= '0;
      crce_r    <= '0;
      lene_r    <= '0;
      chf_r     <= '0;
      active_r  <= 1'b0;
      idx_r     <= 4'd0;
      res_valid <= 1'b0;
    end else if (take) begin
      if (active_r) begin
        res_valid <= 1'b1;
        active_r  <= (idx_r != LAST_IDX);
        idx_r     <= idx_r + 4'd1;
      end else if (job_valid) begin
        res_valid <= 1'b1;
        good_r    <= good_nxt;
        crce_r    <= crce_nxt;
        lene_r    <= lene_nxt;
        chf_r     <= chf_nxt;
        active_r  <= (job.kind == EV_CHANNEL) && (LAST_IDX != 4'd0);
        idx_r     <= 4'd1;
      end else begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (active_r) begin
        res_event <= EV_CHANNEL;
        res_type  <= type_r;
        res_index <= idx_r;
        res_value <= sh_r[CH_BITS-1:0];
        res_last  <= (idx_r == LAST_IDX);
        sh_r      <= sh_r >> CH_BITS;
      end else if (pop) begin
        res_event     <= job.kind;
        res_type      <= job.frame_type;
        type_r        <= job.frame_type;
        res_index     <= 4'd0;
        res_good      <= OUT_CNT_BITS'(good_nxt);
        res_crc_err   <= OUT_CNT_BITS'(crce_nxt);
        res_len_err   <= OUT_CNT_BITS'(lene_nxt);
        res_ch_frames <= OUT_CNT_BITS'(chf_nxt);
        sh_r          <= job.payload >> CH_BITS;
        if (job.kind == EV_CHANNEL) begin
          res_value <= job.payload[CH_BITS-1:0];
          res_last  <= (LAST_IDX == 4'd0);
        end else begin
          res_value <= 11'd0;
          res_last  <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/rc_link_frame_parser_unit.sv
// Top level of the rc link frame parser.
//
//   port     dir  role     payload
//   in_ch    in   sink     rx_byte
//   out_ch   out  source   event_res, frame_type, chan_num, channel_value,
//                          last, good_frames, crc_errors, length_errors,
//                          channel_frames
//
// One byte is taken per cycle while the frame queue has room.
// A frame end yields one result, or CHANNEL_COUNT results for a channel frame,
// one per cycle from the result register; the two-entry queue holds finished
// frames while the result side stalls, and in_ch.ready drops when it is full.
// Reset is synchronous, active low; it clears sync state, queue and counters.
`default_nettype none
module rc_link_frame_parser_unit
  import rclfp_pkg::*;
#(
  parameter int unsigned CHANNEL_COUNT = 16,
  parameter int unsigned COUNTER_BITS  = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rclfp_in_if.sink   in_ch,
  rclfp_out_if.source out_ch
);

  logic f_valid;
  logic f_ready;
  job_t f_job;
  logic q_valid;
  logic q_ready;
  job_t q_job;

  rclfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_ch.valid),
    .byte_data  (in_ch.rx_byte),
    .byte_ready (in_ch.ready),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job)
  );

  rclfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_job    (q_job)
  );

  rclfp_back #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .COUNTER_BITS  (COUNTER_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (q_valid),
    .job_ready     (q_ready),
    .job           (q_job),
    .res_valid     (out_ch.valid),
    .res_ready     (out_ch.ready),
    .res_event     (out_ch.event_res),
    .res_type      (out_ch.frame_type),
    .res_index     (out_ch.chan_num),
    .res_value     (out_ch.channel_value),
    .res_last      (out_ch.last),
    .res_good      (out_ch.good_frames),
    .res_crc_err   (out_ch.crc_errors),
    .res_len_err   (out_ch.length_errors),
    .res_ch_frames (out_ch.channel_frames)
  );

endmodule
`default_nettype wire
